### rtl/psw_pkg.sv
// Shared constants and types for the priority schedule wait-time block.
package psw_pkg;

  // Batch size and derived index widths
  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // Field widths
  localparam int ID_W    = 5;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 16;
  localparam int WAIT_W  = 21;
  localparam int TW_W    = 26;
  localparam int TT_W    = 27;
  localparam int FRAC_W  = 8;
  localparam int AVG_W   = 29;

  // Dividend for the averages: the wider sum with the Q.8 shift applied
  localparam int DVD_W = TT_W + FRAC_W;

  // One stored process slot
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } slot_t;

endpackage

### rtl/psw_div.sv
// Restoring divider, one quotient bit per cycle, for the Q.8 averages.
module psw_div
  import psw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  // Shift one dividend bit into the remainder and try the subtraction
  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    ge       = (trial >= {1'b0, divisor});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
      dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### rtl/priority_schedule_wait_times.sv
// Top level: load, exchange-sort and report a batch of prioritised processes.
// Words are stored in turn; the closing word, or the one that fills the store,
// starts the batch pass: an exchange sort in the slot memory (skipped for one
// process), then for each row a memory read, a capture and an output, with both
// divisions run before the last row is released.
// Input is stalled during the batch pass.
// Synchronous active-low reset clears control and sums; slot memory is kept.
module priority_schedule_wait_times
  import psw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRIO_W-1:0]  in_priority_level,
  input  logic               in_is_final,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_proc_id,
  output logic [PRIO_W-1:0]  out_prio_out,
  output logic [BURST_W-1:0] out_burst_out,
  output logic [WAIT_W-1:0]  out_wait_time,
  output logic [WAIT_W-1:0]  out_turnaround,
  output logic [AVG_W-1:0]   out_avg_wait_q8,
  output logic [AVG_W-1:0]   out_avg_turn_q8,
  output logic               out_row_last
);

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_SORT_LD = 4'd2;
  localparam logic [3:0] ST_SORT_K  = 4'd3;
  localparam logic [3:0] ST_SORT_WB = 4'd4;
  localparam logic [3:0] ST_EM_RD   = 4'd5;
  localparam logic [3:0] ST_EM_DAT  = 4'd6;
  localparam logic [3:0] ST_EM_OUT  = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;

  // Slot memory
  slot_t mem [MAX_PROCS];
  slot_t rdata_r;
  logic  [IDX_W-1:0] raddr, waddr;
  logic  we;
  slot_t wdata;

  // Control
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             ov_r, ov_nxt;

  // Datapath
  slot_t             cur_r, cur_nxt;
  slot_t             row_r, row_nxt;
  logic [WAIT_W-1:0] acc_r, acc_nxt;
  logic [TW_W-1:0]   tw_r, tw_nxt;
  logic [TT_W-1:0]   tt_r, tt_nxt;

  // Output payload
  logic [ID_W-1:0]    o_id_r, o_id_nxt;
  logic [PRIO_W-1:0]  o_prio_r, o_prio_nxt;
  logic [BURST_W-1:0] o_burst_r, o_burst_nxt;
  logic [WAIT_W-1:0]  o_wait_r, o_wait_nxt;
  logic [WAIT_W-1:0]  o_turn_r, o_turn_nxt;
  logic [AVG_W-1:0]   o_aw_r, o_aw_nxt;
  logic [AVG_W-1:0]   o_at_r, o_at_nxt;
  logic               o_last_r, o_last_nxt;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] dvd_w, dvd_t;
  logic             done_w, done_t;
  logic [DVD_W-1:0] q_w, q_t;

  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] n_m1;
  logic [WAIT_W-1:0] turn;
  logic             row_is_last;

  assign in_acc      = in_valid && (state_r == ST_LOAD);
  assign out_free    = !ov_r || !out_stall;
  assign n_m1        = n_r - 1'b1;
  assign turn        = acc_r + WAIT_W'(row_r.burst);
  assign row_is_last = ({{(CNT_W-IDX_W){1'b0}}, j_r} == n_m1);

  // Sequence loading, sorting and row output
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    cur_nxt     = cur_r;
    row_nxt     = row_r;
    acc_nxt     = acc_r;
    tw_nxt      = tw_r;
    tt_nxt      = tt_r;
    o_id_nxt    = o_id_r;
    o_prio_nxt  = o_prio_r;
    o_burst_nxt = o_burst_r;
    o_wait_nxt  = o_wait_r;
    o_turn_nxt  = o_turn_r;
    o_aw_nxt    = o_aw_r;
    o_at_nxt    = o_at_r;
    o_last_nxt  = o_last_r;
    ov_nxt      = ov_r && out_stall;
    raddr       = '0;
    waddr       = cnt_r[IDX_W-1:0];
    wdata       = cur_r;
    we          = 1'b0;
    div_start   = 1'b0;
    dvd_w       = {{(DVD_W-TW_W-FRAC_W){1'b0}}, tw_r, {FRAC_W{1'b0}}};
    dvd_t       = {tt_r, {FRAC_W{1'b0}}};

    case (state_r)
      ST_LOAD: begin
        // Store the word at the next slot; close on final word or full store
        if (in_acc) begin
          we          = 1'b1;
          waddr       = cnt_r[IDX_W-1:0];
          wdata.id    = ID_W'(cnt_r);
          wdata.burst = in_burst_time;
          wdata.prio  = in_priority_level;
          cnt_nxt     = cnt_r + 1'b1;
          if (in_is_final || (cnt_r == CNT_W'(MAX_PROCS - 1))) begin
            n_nxt     = cnt_r + 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        // Read slot 0 and clear the sums
        raddr   = '0;
        i_nxt   = '0;
        j_nxt   = '0;
        acc_nxt = '0;
        tw_nxt  = '0;
        tt_nxt  = '0;
        state_nxt = (n_r == CNT_W'(1)) ? ST_EM_DAT : ST_SORT_LD;
      end
      ST_SORT_LD: begin
        // Hold slot i and start reading the later slots
        cur_nxt   = rdata_r;
        raddr     = i_r + 1'b1;
        k_nxt     = i_r + 1'b1;
        state_nxt = ST_SORT_K;
      end
      ST_SORT_K: begin
        // Exchange when the held slot has the larger priority
        if (cur_r.prio > rdata_r.prio) begin
          we      = 1'b1;
          waddr   = k_r;
          wdata   = cur_r;
          cur_nxt = rdata_r;
        end
        if ({{(CNT_W-IDX_W){1'b0}}, k_r} == n_m1) begin
          state_nxt = ST_SORT_WB;
        end else begin
          raddr = k_r + 1'b1;
          k_nxt = k_r + 1'b1;
        end
      end
      ST_SORT_WB: begin
        // Write back slot i and advance to the next pass
        we    = 1'b1;
        waddr = i_r;
        wdata = cur_r;
        i_nxt = i_r + 1'b1;
        raddr = i_r + 1'b1;
        if ({{(CNT_W-IDX_W){1'b0}}, i_r} == CNT_W'(n_r - CNT_W'(2))) begin
          j_nxt     = '0;
          state_nxt = ST_EM_RD;
        end else begin
          state_nxt = ST_SORT_LD;
        end
      end
      ST_EM_RD: begin
        raddr     = j_r;
        state_nxt = ST_EM_DAT;
      end
      ST_EM_DAT: begin
        row_nxt   = rdata_r;
        state_nxt = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        // Hand the row to the output register once it is free
        if (out_free) begin
          o_id_nxt    = row_r.id;
          o_prio_nxt  = row_r.prio;
          o_burst_nxt = row_r.burst;
          o_wait_nxt  = acc_r;
          o_turn_nxt  = turn;
          o_aw_nxt    = '0;
          o_at_nxt    = '0;
          o_last_nxt  = 1'b0;
          acc_nxt     = turn;
          tw_nxt      = tw_r + TW_W'(acc_r);
          tt_nxt      = tt_r + TT_W'(turn);
          j_nxt       = j_r + 1'b1;
          if (row_is_last) begin
            // Final row waits for the averages
            ov_nxt    = 1'b0;
            div_start = 1'b1;
            dvd_w     = {{(DVD_W-TW_W-FRAC_W){1'b0}}, tw_nxt, {FRAC_W{1'b0}}};
            dvd_t     = {tt_nxt, {FRAC_W{1'b0}}};
            state_nxt = ST_DIV;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = ST_EM_RD;
          end
        end
      end
      ST_DIV: begin
        // Release the final row with both averages
        if (done_w) begin
          o_aw_nxt   = q_w[AVG_W-1:0];
          o_at_nxt   = q_t[AVG_W-1:0];
          o_last_nxt = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      ov_r    <= 1'b0;
      acc_r   <= '0;
      tw_r    <= '0;
      tt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
      acc_r   <= acc_nxt;
      tw_r    <= tw_nxt;
      tt_r    <= tt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    row_r     <= row_nxt;
    o_id_r    <= o_id_nxt;
    o_prio_r  <= o_prio_nxt;
    o_burst_r <= o_burst_nxt;
    o_wait_r  <= o_wait_nxt;
    o_turn_r  <= o_turn_nxt;
    o_aw_r    <= o_aw_nxt;
    o_at_r    <= o_at_nxt;
    o_last_r  <= o_last_nxt;
  end

  psw_div u_div_wait (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_w),
    .divisor  (n_r),
    .done     (done_w),
    .quotient (q_w)
  );

  psw_div u_div_turn (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_t),
    .divisor  (n_r),
    .done     (done_t),
    .quotient (q_t)
  );

  assign in_stall        = (state_r != ST_LOAD) || (done_t && 1'b0);
  assign out_valid       = ov_r;
  assign out_proc_id     = o_id_r;
  assign out_prio_out    = o_prio_r;
  assign out_burst_out   = o_burst_r;
  assign out_wait_time   = o_wait_r;
  assign out_turnaround  = o_turn_r;
  assign out_avg_wait_q8 = o_aw_r;
  assign out_avg_turn_q8 = o_at_r;
  assign out_row_last    = o_last_r;

endmodule

### verif/tb_priority_schedule_wait_times.sv
`timescale 1ns / 100ps
// Self-checking testbench for the priority schedule wait-time block.
module tb_priority_schedule_wait_times;
  import psw_pkg::*;

  // The slowest batch is a full store of 32 processes with stalled rows; a dozen
  // full batches, the long hold-off and all gaps stay far below this.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int PHASE_WORDS  = 88;
  localparam int DRAIN_CYCLES = 100;
  localparam int SHOW_LIMIT   = 10;

  // One process word waiting to be offered
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               closing;
    logic               hold_back;
  } proc_word_t;

  // One schedule row as the block should report it
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [WAIT_W-1:0]  waiting;
    logic [WAIT_W-1:0]  turn;
    logic [AVG_W-1:0]   avg_wait;
    logic [AVG_W-1:0]   avg_turn;
    logic               last_row;
  } sched_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BURST_W-1:0] in_burst_time = '0;
  logic [PRIO_W-1:0]  in_priority_level = '0;
  logic               in_is_final = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ID_W-1:0]    out_proc_id;
  logic [PRIO_W-1:0]  out_prio_out;
  logic [BURST_W-1:0] out_burst_out;
  logic [WAIT_W-1:0]  out_wait_time;
  logic [WAIT_W-1:0]  out_turnaround;
  logic [AVG_W-1:0]   out_avg_wait_q8;
  logic [AVG_W-1:0]   out_avg_turn_q8;
  logic               out_row_last;

  proc_word_t  pending_words[$];
  sched_row_t  sched_rows_due[$];
  proc_word_t  next_word;
  slot_t       held_slots[MAX_PROCS];
  int unsigned held_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          phase_no = 0;
  logic        in_took = 1'b0;
  logic        long_hold = 1'b0;

  priority_schedule_wait_times dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_burst_time     (in_burst_time),
    .in_priority_level (in_priority_level),
    .in_is_final       (in_is_final),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_proc_id       (out_proc_id),
    .out_prio_out      (out_prio_out),
    .out_burst_out     (out_burst_out),
    .out_wait_time     (out_wait_time),
    .out_turnaround    (out_turnaround),
    .out_avg_wait_q8   (out_avg_wait_q8),
    .out_avg_turn_q8   (out_avg_turn_q8),
    .out_row_last      (out_row_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Store one accepted word; on a closing word or a full store sort the batch and queue its rows
  function automatic void admit_process(input logic [BURST_W-1:0] burst,
                                        input logic [PRIO_W-1:0]  prio,
                                        input logic               closing);
    sched_row_t  rows[MAX_PROCS];
    slot_t       tmp;
    logic [63:0] acc;
    logic [63:0] turn;
    logic [63:0] total_w;
    logic [63:0] total_t;
    logic [63:0] avg;
    int unsigned n;
    held_slots[held_count].id    = ID_W'(held_count);
    held_slots[held_count].burst = burst;
    held_slots[held_count].prio  = prio;
    held_count++;
    if (!closing && held_count < MAX_PROCS) return;
    n = held_count;
    // Exchange sort, unstable: ties keep the order this swap pattern gives
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k < n; k++) begin
        if (held_slots[i].prio > held_slots[k].prio) begin
          tmp           = held_slots[i];
          held_slots[i] = held_slots[k];
          held_slots[k] = tmp;
        end
      end
    end
    acc = '0;
    total_w = '0;
    total_t = '0;
    for (int i = 0; i < n; i++) begin
      turn = acc + 64'(held_slots[i].burst);
      rows[i].id       = held_slots[i].id;
      rows[i].prio     = held_slots[i].prio;
      rows[i].burst    = held_slots[i].burst;
      rows[i].waiting  = acc[WAIT_W-1:0];
      rows[i].turn     = turn[WAIT_W-1:0];
      rows[i].avg_wait = '0;
      rows[i].avg_turn = '0;
      rows[i].last_row = 1'b0;
      total_w += acc;
      total_t += turn;
      acc = turn;
    end
    // Averages in Q.8, truncated, on the last row only
    avg = (total_w << FRAC_W) / 64'(n);
    rows[n-1].avg_wait = avg[AVG_W-1:0];
    avg = (total_t << FRAC_W) / 64'(n);
    rows[n-1].avg_turn = avg[AVG_W-1:0];
    rows[n-1].last_row = 1'b1;
    for (int i = 0; i < n; i++) sched_rows_due.push_back(rows[i]);
    held_count = 0;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    sched_row_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        admit_process(in_burst_time, in_priority_level, in_is_final);
      if (out_valid && !out_stall) begin
        if (sched_rows_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected row: proc_id %0d, burst %0d", out_proc_id, out_burst_out);
        end else begin
          want = sched_rows_due.pop_front();
          check_field("proc_id", want.id, out_proc_id);
          check_field("prio_out", want.prio, out_prio_out);
          check_field("burst_out", want.burst, out_burst_out);
          check_field("wait_time", want.waiting, out_wait_time);
          check_field("turnaround", want.turn, out_turnaround);
          check_field("avg_wait_q8", want.avg_wait, out_avg_wait_q8);
          check_field("avg_turn_q8", want.avg_turn, out_avg_turn_q8);
          check_field("row_last", want.last_row, out_row_last);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer the next word at the falling edge; hold a marked word until rows drain
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_words.size() != 0 &&
          !(pending_words[0].hold_back && sched_rows_due.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_burst_time     <= next_word.burst;
        in_priority_level <= next_word.prio;
        in_is_final       <= next_word.closing;
        in_valid          <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Hold off the receiver for a long stretch at the start of the last phase
  initial begin
    while (phase_no != 3) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic push_word(input logic [BURST_W-1:0] burst,
                           input logic [PRIO_W-1:0] prio, input logic closing);
    proc_word_t w;
    w = '{burst: burst, prio: prio, closing: closing, hold_back: 1'b0};
    pending_words.push_back(w);
  endtask

  // Queue one batch of random words; a full batch sets the closing flag at random
  task automatic queue_batch(input int n, input bit all_max, input bit pause);
    proc_word_t w;
    int burst_style;
    int prio_style;
    burst_style = $urandom_range(2);
    prio_style  = $urandom_range(2);
    for (int j = 0; j < n; j++) begin
      case (burst_style)
        0: w.burst = BURST_W'($urandom);
        1: w.burst = BURST_W'($urandom_range(15));
        default: w.burst = $urandom_range(1) ? '1 : '0;
      endcase
      if (all_max) w.burst = '1;
      case (prio_style)
        0: w.prio = PRIO_W'($urandom);
        1: w.prio = PRIO_W'($urandom_range(3));
        default: w.prio = $urandom_range(1) ? '1 : '0;
      endcase
      if (j == n - 1) w.closing = (n == MAX_PROCS) ? 1'($urandom_range(1)) : 1'b1;
      else            w.closing = 1'b0;
      w.hold_back = pause && (j == 0);
      pending_words.push_back(w);
    end
  endtask

  task automatic random_phase(input int words, input bit with_pause);
    int queued;
    int n;
    bit paused;
    queued = 0;
    paused = 0;
    while (queued < words) begin
      n = ($urandom_range(11) == 0) ? MAX_PROCS : $urandom_range(8, 1);
      queue_batch(n, 1'b0, with_pause && !paused && queued >= words / 2);
      if (with_pause && queued >= words / 2) paused = 1;
      queued += n;
    end
  endtask

  task automatic drain_phase();
    while (pending_words.size() != 0 || in_valid || sched_rows_due.size() != 0)
      @(posedge clk);
  endtask

  // Reset, then run three phases and judge the run
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    phase_no = 1;
    send_idle_pct = 11;
    recv_idle_pct = 68;
    // Single-process batches at both extremes
    push_word('0, '0, 1'b1);
    push_word('1, '1, 1'b1);
    // Tied priorities: the exchange sort reorders equal keys
    push_word(16'd5, 16'd2, 1'b0);
    push_word(16'd7, 16'd1, 1'b0);
    push_word(16'd0, 16'd2, 1'b0);
    push_word(16'd9, 16'd1, 1'b0);
    push_word(16'd3, 16'd0, 1'b0);
    push_word('1, 16'd2, 1'b1);
    // Reverse order
    push_word(16'd100, '1, 1'b0);
    push_word(16'd200, 16'd40000, 1'b0);
    push_word(16'd300, 16'd1, 1'b0);
    push_word(16'd400, '0, 1'b1);
    // All equal
    push_word(16'd1, 16'd7, 1'b0);
    push_word(16'd2, 16'd7, 1'b0);
    push_word(16'd3, 16'd7, 1'b1);
    // Full store of maximum bursts; the closing flag is set at random
    queue_batch(MAX_PROCS, 1'b1, 1'b0);
    random_phase(PHASE_WORDS, 1'b0);
    drain_phase();

    phase_no = 2;
    send_idle_pct = 68;
    recv_idle_pct = 11;
    random_phase(PHASE_WORDS, 1'b1);
    drain_phase();

    // Fill the block while the receiver holds off
    phase_no = 3;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_batch(MAX_PROCS, 1'b1, 1'b0);
    random_phase(PHASE_WORDS, 1'b0);
    drain_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sched_rows_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/psw_pkg.sv
rtl/psw_div.sv
rtl/priority_schedule_wait_times.sv
verif/tb_priority_schedule_wait_times.sv
